FILE: rtl/core/dmwtc_pkg.sv
// Shared constants, types and address helpers for the direct-mapped write-through cache.
`timescale 1ns / 1ps

package dmwtc_pkg;

    localparam int LINES       = 256;
    localparam int LINE_BYTES  = 8;
    localparam int ADDR_W      = 32;
    localparam int WORD_BYTES  = 32 / 8;
    localparam int OFF_W       = $clog2(LINE_BYTES);
    localparam int IDX_W       = $clog2(LINES);
    localparam int TAG_W       = ADDR_W - OFF_W - IDX_W;
    localparam int LINE_W      = 8 * LINE_BYTES;
    localparam int FILL_W      = 64;
    localparam int STEP_W      = $clog2(WORD_BYTES);
    localparam int NEIGHBORS   = WORD_BYTES - 1;
    localparam int CMD_W       = 2;
    localparam int IN_DATA_W   = ADDR_W + ADDR_W + FILL_W;
    localparam int OUT_DATA_W  = 8 + ADDR_W + ADDR_W;
    localparam int OUT_USER_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FILL  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_READ  = 2'd1,
        PEND_WRITE = 2'd2
    } pend_t;

    typedef enum logic [2:0] {
        RES_NONE  = 3'd0,
        RES_HIT   = 3'd1,
        RES_MISS  = 3'd2,
        RES_WRITE = 3'd3,
        RES_FILL  = 3'd4
    } res_t;

    typedef struct packed {
        logic              take;
        logic              lookup_rd;
        logic              fill_wr;
        logic              pend_ld;
        logic              inv_rd;
        logic              inv_chk;
        logic              out_ld;
        res_t              res_kind;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic lookup_hit;
        logic out_free;
    } dp_stat_t;

    function automatic logic [IDX_W-1:0] index_of(input logic [ADDR_W-1:0] addr);
        logic [IDX_W-1:0] raw;
        logic [IDX_W-1:0] idx;
        raw = addr[OFF_W +: IDX_W];
        idx = raw;
        if ({1'b0, raw} >= (IDX_W + 1)'(LINES))
        begin
            idx = raw - IDX_W'(LINES);
        end
        return idx;
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] addr);
        return addr[ADDR_W-1 -: TAG_W];
    endfunction

    function automatic logic [7:0] byte_of(input logic [LINE_W-1:0] line,
                                           input logic [ADDR_W-1:0] addr);
        logic [OFF_W-1:0] off;
        logic [7:0]       b;
        off = addr[OFF_W-1:0];
        b   = 8'd0;
        if ({1'b0, off} < (OFF_W + 1)'(LINE_BYTES))
        begin
            b = line[8 * int'(off) +: 8];
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/dmwtc_dp.sv
// Datapath of the cache: item registers, tag and line memories, valid bits and output register.
`timescale 1ns / 1ps

module dmwtc_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [dmwtc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                  m_axis_tready,
    input  dmwtc_pkg::dp_cmd_t                    cmd,
    output dmwtc_pkg::dp_stat_t                   stat,
    output logic                                  m_axis_tvalid,
    output logic [dmwtc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [dmwtc_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

    logic [dmwtc_pkg::ADDR_W-1:0] in_addr;
    logic [dmwtc_pkg::ADDR_W-1:0] in_wdata;
    logic [dmwtc_pkg::FILL_W-1:0] in_fill;

    logic [dmwtc_pkg::ADDR_W-1:0] addr_reg;
    logic [dmwtc_pkg::ADDR_W-1:0] wdata_reg;
    logic [dmwtc_pkg::FILL_W-1:0] fill_reg;
    logic [dmwtc_pkg::ADDR_W-1:0] pend_addr_reg;
    logic [dmwtc_pkg::ADDR_W-1:0] nb_addr_reg;
    logic [dmwtc_pkg::ADDR_W-1:0] nb_addr_next;

    logic [dmwtc_pkg::TAG_W-1:0]  tag_mem [dmwtc_pkg::LINES];
    logic [dmwtc_pkg::LINE_W-1:0] data_mem [dmwtc_pkg::LINES];
    logic [dmwtc_pkg::TAG_W-1:0]  tag_q;
    logic [dmwtc_pkg::LINE_W-1:0] data_q;
    logic [dmwtc_pkg::IDX_W-1:0]  rd_idx;
    logic [dmwtc_pkg::IDX_W-1:0]  fill_idx;
    logic [dmwtc_pkg::IDX_W-1:0]  nb_idx;
    logic                         nb_match;

    logic [dmwtc_pkg::LINES-1:0]  valid_reg;
    logic [dmwtc_pkg::LINES-1:0]  valid_next;

    logic                         m_valid_reg;
    logic                         m_valid_next;
    logic [dmwtc_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [dmwtc_pkg::OUT_USER_W-1:0] m_user_reg;

    logic                         res_done;
    logic                         res_hit;
    logic [7:0]                   res_byte;
    logic                         res_req;
    logic                         res_wr;
    logic [dmwtc_pkg::ADDR_W-1:0] res_addr;
    logic [dmwtc_pkg::ADDR_W-1:0] res_wdata;

    assign in_addr  = s_axis_tdata[dmwtc_pkg::ADDR_W-1:0];
    assign in_wdata = s_axis_tdata[2*dmwtc_pkg::ADDR_W-1:dmwtc_pkg::ADDR_W];
    assign in_fill  = s_axis_tdata[dmwtc_pkg::IN_DATA_W-1:2*dmwtc_pkg::ADDR_W];

    assign nb_addr_next = pend_addr_reg
                        + dmwtc_pkg::ADDR_W'(cmd.step)
                        * dmwtc_pkg::ADDR_W'(dmwtc_pkg::LINE_BYTES);
    assign rd_idx   = cmd.inv_rd ? dmwtc_pkg::index_of(nb_addr_next)
                                 : dmwtc_pkg::index_of(in_addr);
    assign fill_idx = dmwtc_pkg::index_of(pend_addr_reg);
    assign nb_idx   = dmwtc_pkg::index_of(nb_addr_reg);
    assign nb_match = valid_reg[nb_idx] && (tag_q == dmwtc_pkg::tag_of(nb_addr_reg));

    assign stat.lookup_hit = valid_reg[dmwtc_pkg::index_of(addr_reg)]
                          && (tag_q == dmwtc_pkg::tag_of(addr_reg));
    assign stat.out_free   = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
        begin
            tag_mem[fill_idx]  <= dmwtc_pkg::tag_of(pend_addr_reg);
            data_mem[fill_idx] <= in_fill[dmwtc_pkg::LINE_W-1:0];
        end
        if (cmd.lookup_rd || cmd.inv_rd)
        begin
            tag_q <= tag_mem[rd_idx];
        end
        if (cmd.lookup_rd)
        begin
            data_q <= data_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            addr_reg  <= in_addr;
            wdata_reg <= in_wdata;
            fill_reg  <= in_fill;
        end
        if (cmd.inv_rd)
        begin
            nb_addr_reg <= nb_addr_next;
        end
        if (cmd.out_ld)
        begin
            m_data_reg <= {res_wdata, res_addr, res_byte};
            m_user_reg <= {res_wr, res_req, res_hit, res_done};
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.fill_wr)
        begin
            valid_next[fill_idx] = 1'b1;
        end
        if (cmd.inv_chk && nb_match)
        begin
            valid_next[nb_idx] = 1'b0;
        end
    end

    always_comb
    begin
        res_done  = 1'b0;
        res_hit   = 1'b0;
        res_byte  = 8'd0;
        res_req   = 1'b0;
        res_wr    = 1'b0;
        res_addr  = '0;
        res_wdata = '0;
        case (cmd.res_kind)
            dmwtc_pkg::RES_HIT:
            begin
                res_done = 1'b1;
                res_hit  = 1'b1;
                res_byte = dmwtc_pkg::byte_of(data_q, addr_reg);
            end
            dmwtc_pkg::RES_MISS:
            begin
                res_req  = 1'b1;
                res_addr = addr_reg;
            end
            dmwtc_pkg::RES_WRITE:
            begin
                res_req   = 1'b1;
                res_wr    = 1'b1;
                res_addr  = addr_reg;
                res_wdata = wdata_reg;
            end
            dmwtc_pkg::RES_FILL:
            begin
                res_done = 1'b1;
                res_byte = dmwtc_pkg::byte_of(fill_reg[dmwtc_pkg::LINE_W-1:0],
                                              pend_addr_reg);
            end
            default:
            begin
                res_done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.out_ld)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            pend_addr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cmd.pend_ld)
            begin
                pend_addr_reg <= addr_reg;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

FILE: rtl/core/dmwtc_ctrl.sv
// Controller state machine of the cache: access decode, pending request and invalidation steps.
`timescale 1ns / 1ps

module dmwtc_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic [dmwtc_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                             s_axis_tready,
    input  dmwtc_pkg::dp_stat_t              stat,
    output dmwtc_pkg::dp_cmd_t               cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_LOOK    = 5'b00010,
        S_INV_RD  = 5'b00100,
        S_INV_CHK = 5'b01000,
        S_PUSH    = 5'b10000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    dmwtc_pkg::pend_t               pend_reg;
    dmwtc_pkg::pend_t               pend_next;
    dmwtc_pkg::res_t                res_reg;
    dmwtc_pkg::res_t                res_next;
    logic [dmwtc_pkg::STEP_W-1:0]   step_reg;
    logic [dmwtc_pkg::STEP_W-1:0]   step_next;
    logic                           take;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        step_next  = step_reg;

        cmd           = '0;
        cmd.take      = take;
        cmd.res_kind  = res_reg;
        cmd.step      = step_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_PUSH;
                    res_next   = dmwtc_pkg::RES_NONE;
                    unique case (dmwtc_pkg::cmd_t'(s_axis_tuser))
                        dmwtc_pkg::CMD_READ:
                        begin
                            if (pend_reg == dmwtc_pkg::PEND_NONE)
                            begin
                                cmd.lookup_rd = 1'b1;
                                state_next    = S_LOOK;
                            end
                        end
                        dmwtc_pkg::CMD_WRITE:
                        begin
                            if (pend_reg == dmwtc_pkg::PEND_NONE)
                            begin
                                res_next  = dmwtc_pkg::RES_WRITE;
                                pend_next = dmwtc_pkg::PEND_WRITE;
                            end
                        end
                        dmwtc_pkg::CMD_FILL:
                        begin
                            if (pend_reg != dmwtc_pkg::PEND_NONE)
                            begin
                                cmd.fill_wr = 1'b1;
                                res_next    = dmwtc_pkg::RES_FILL;
                                pend_next   = dmwtc_pkg::PEND_NONE;
                                if (pend_reg == dmwtc_pkg::PEND_WRITE)
                                begin
                                    step_next  = dmwtc_pkg::STEP_W'(1);
                                    state_next = S_INV_RD;
                                end
                            end
                        end
                        default:
                        begin
                            res_next = dmwtc_pkg::RES_NONE;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                state_next = S_PUSH;
                if (stat.lookup_hit)
                begin
                    res_next = dmwtc_pkg::RES_HIT;
                end
                else
                begin
                    res_next  = dmwtc_pkg::RES_MISS;
                    pend_next = dmwtc_pkg::PEND_READ;
                end
            end
            S_INV_RD:
            begin
                cmd.inv_rd = 1'b1;
                state_next = S_INV_CHK;
            end
            S_INV_CHK:
            begin
                cmd.inv_chk = 1'b1;
                if (step_reg == dmwtc_pkg::STEP_W'(dmwtc_pkg::NEIGHBORS))
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    step_next  = step_reg + dmwtc_pkg::STEP_W'(1);
                    state_next = S_INV_RD;
                end
            end
            S_PUSH:
            begin
                cmd.pend_ld = (res_reg == dmwtc_pkg::RES_MISS)
                           || (res_reg == dmwtc_pkg::RES_WRITE);
                if (stat.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= dmwtc_pkg::PEND_NONE;
            res_reg   <= dmwtc_pkg::RES_NONE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            res_reg   <= res_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: rtl/core/direct_mapped_write_through_cache_unit.sv
// Top level of the direct-mapped write-through cache with line refill.
// The cache takes one word at a time and gives exactly one result word for each. A read passes
// through acceptance, the tag and line RAM read and the result register; a write, an ignored
// word and a fill that completes a read go from acceptance straight to the result register, and
// a fill that completes a write first checks the three following lines one after another through
// the single read port of the tag RAM. A new word is accepted as soon as the previous one has
// reached the output register, even while that result still waits to be taken; a result that
// is not taken holds the next one back.
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // address [31:0], write_data [63:32], fill_data [127:64]
    input  logic [dmwtc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // cmd [1:0]
    input  logic [dmwtc_pkg::CMD_W-1:0]           s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // read_byte [7:0], mem_addr [39:8], mem_wdata [71:40]
    output logic [dmwtc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // done_res [0], hit [1], mem_req [2], mem_write [3]
    output logic [dmwtc_pkg::OUT_USER_W-1:0]      m_axis_tuser
);

    dmwtc_pkg::dp_cmd_t  dp_cmd;
    dmwtc_pkg::dp_stat_t dp_stat;

    dmwtc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .stat          (dp_stat),
        .cmd           (dp_cmd)
    );

    dmwtc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: dv/dmwtc_result_checker.sv
// Result checker for the direct-mapped write-through cache: predicts each result word and compares.
`timescale 1ns / 1ps

module dmwtc_result_checker
    import dmwtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [CMD_W-1:0]      s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [OUT_USER_W-1:0] m_axis_tuser,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic        done_res;
        logic        hit;
        logic [7:0]  read_byte;
        logic        mem_req;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
    } cache_result_t;

    logic [TAG_W-1:0]  shadow_tag [LINES];
    logic              shadow_valid [LINES];
    logic [LINE_W-1:0] shadow_line [LINES];
    pend_t             shadow_pend;
    logic [ADDR_W-1:0] shadow_pend_addr;

    cache_result_t     expected_results [$];
    cache_result_t     predicted;
    cache_result_t     observed;
    cache_result_t     oldest;
    int                err_cnt;

    assign mismatches  = err_cnt;
    assign outstanding = expected_results.size();

    task predict_cache_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] wdata, input logic [FILL_W-1:0] fill,
                            output cache_result_t res);
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  nidx;
        logic [ADDR_W-1:0] naddr;
        int                off;
        res = '0;
        case (cmd)
            CMD_READ:
            begin
                if (shadow_pend == PEND_NONE)
                begin
                    idx = addr[OFF_W +: IDX_W];
                    off = int'(addr[OFF_W-1:0]);
                    if (shadow_valid[idx] && shadow_tag[idx] == addr[ADDR_W-1 -: TAG_W])
                    begin
                        res.done_res  = 1'b1;
                        res.hit       = 1'b1;
                        res.read_byte = shadow_line[idx][8*off +: 8];
                    end
                    else
                    begin
                        res.mem_req      = 1'b1;
                        res.mem_addr     = addr;
                        shadow_pend      = PEND_READ;
                        shadow_pend_addr = addr;
                    end
                end
            end
            CMD_WRITE:
            begin
                if (shadow_pend == PEND_NONE)
                begin
                    res.mem_req      = 1'b1;
                    res.mem_write    = 1'b1;
                    res.mem_addr     = addr;
                    res.mem_wdata    = wdata;
                    shadow_pend      = PEND_WRITE;
                    shadow_pend_addr = addr;
                end
            end
            CMD_FILL:
            begin
                if (shadow_pend != PEND_NONE)
                begin
                    idx = shadow_pend_addr[OFF_W +: IDX_W];
                    off = int'(shadow_pend_addr[OFF_W-1:0]);
                    shadow_tag[idx]   = shadow_pend_addr[ADDR_W-1 -: TAG_W];
                    shadow_line[idx]  = fill[LINE_W-1:0];
                    shadow_valid[idx] = 1'b1;
                    res.done_res      = 1'b1;
                    res.read_byte     = fill[8*off +: 8];
                    if (shadow_pend == PEND_WRITE)
                    begin
                        for (int i = 1; i < WORD_BYTES; i++)
                        begin
                            naddr = shadow_pend_addr + ADDR_W'(i * LINE_BYTES);
                            nidx  = naddr[OFF_W +: IDX_W];
                            if (shadow_valid[nidx] &&
                                shadow_tag[nidx] == naddr[ADDR_W-1 -: TAG_W])
                            begin
                                shadow_valid[nidx] = 1'b0;
                            end
                        end
                    end
                    shadow_pend = PEND_NONE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_tag[i]   = '0;
                shadow_line[i]  = '0;
            end
            shadow_pend      = PEND_NONE;
            shadow_pend_addr = '0;
            err_cnt          = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                observed.done_res  = m_axis_tuser[0];
                observed.hit       = m_axis_tuser[1];
                observed.mem_req   = m_axis_tuser[2];
                observed.mem_write = m_axis_tuser[3];
                observed.read_byte = m_axis_tdata[7:0];
                observed.mem_addr  = m_axis_tdata[39:8];
                observed.mem_wdata = m_axis_tdata[71:40];
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result word, expected none, actual %h",
                             $time, observed);
                    err_cnt++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("done_res", 32'(oldest.done_res), 32'(observed.done_res));
                    check_field("hit", 32'(oldest.hit), 32'(observed.hit));
                    check_field("read_byte", 32'(oldest.read_byte), 32'(observed.read_byte));
                    check_field("mem_req", 32'(oldest.mem_req), 32'(observed.mem_req));
                    check_field("mem_write", 32'(oldest.mem_write), 32'(observed.mem_write));
                    check_field("mem_addr", oldest.mem_addr, observed.mem_addr);
                    check_field("mem_wdata", oldest.mem_wdata, observed.mem_wdata);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_cache_word(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                                   s_axis_tdata[127:64], predicted);
                expected_results.push_back(predicted);
            end
        end
    end

endmodule

FILE: dv/direct_mapped_write_through_cache_unit_tb.sv
// Testbench top for the direct-mapped write-through cache: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module direct_mapped_write_through_cache_unit_tb;

    import dmwtc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_WORDS = 900;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = CMD_READ;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int          mismatches;
    int          outstanding;
    int          words_sent = 0;
    int          idle_cycles = 0;
    bit          tx_free = 1'b0;
    bit          rx_free = 1'b0;
    bit          hold_rx = 1'b0;
    logic [31:0] hot_base [8];
    logic [31:0] pick_addr;
    int          seq_kind;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    direct_mapped_write_through_cache_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dmwtc_result_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 96)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [63:0] rand_line();
        return {$urandom, $urandom};
    endfunction

    task send_word(input logic [CMD_W-1:0] cmd, input logic [31:0] addr,
                   input logic [31:0] wdata, input logic [63:0] fill);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {fill, wdata, addr};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        words_sent++;
        gap = tx_free ? 0 : idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The offer is withdrawn first, so that no word is taken twice while the results drain.
    task wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        forever
        begin
            if (hold_rx)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rx = 1'b0;
            end
            else if (rx_free)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_axis_tready <= 1'b0;
                repeat (idle_len() + 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("direct_mapped_write_through_cache_unit regression: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        hot_base[0] = 32'h0000_0000;
        hot_base[1] = 32'hFFFF_FFD0;
        hot_base[2] = $urandom;
        hot_base[3] = hot_base[2] ^ 32'h0000_0800;
        hot_base[4] = 32'h7FFF_F7E0;
        hot_base[5] = $urandom & 32'hFFFF_FFC0;
        hot_base[6] = $urandom;
        hot_base[7] = hot_base[6] ^ 32'h8000_0000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_READ, 32'h0000_0000, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, 64'h0123_4567_89AB_CDEF);
        send_word(CMD_READ, 32'h0000_0007, 32'h0, 64'h0);
        send_word(CMD_READ, 32'hFFFF_FFFF, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_READ, 32'hFFFF_FFF8, 32'h0, 64'h0);
        send_word(CMD_READ, 32'hFFFF_FFF0, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, 64'h5A5A_A5A5_0F0F_F0F0);
        send_word(CMD_WRITE, 32'hFFFF_FFE8, 32'hFFFF_FFFF, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, 64'h8000_0000_0000_0001);
        send_word(CMD_READ, 32'h0000_0003, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, 64'h0);
        send_word(CMD_READ, 32'hFFFF_FFF8, 32'h0, 64'h0);
        send_word(CMD_WRITE, 32'h0000_0100, 32'hDEAD_BEEF, 64'h0);
        send_word(CMD_READ, 32'h0000_0000, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, rand_line());
        send_word(CMD_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(CMD_WRITE, 32'h0000_0000, 32'h0000_0000, 64'h0);
        send_word(CMD_RSVD, 32'h0000_0000, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, 64'h0);
        send_word(CMD_READ, 32'h0000_0800, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, rand_line());
        send_word(CMD_READ, 32'h0000_0005, 32'h0, 64'h0);
        send_word(CMD_FILL, 32'h0, 32'h0, rand_line());
        wait_drained();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if (words_sent >= 250 && words_sent < 260 && !hold_rx)
            begin
                hold_rx = 1'b1;
            end
            if (words_sent >= 450 && words_sent < 456)
            begin
                wait_drained();
            end
            tx_free = (words_sent >= 600 && words_sent < 700);
            rx_free = tx_free;
            pick_addr = hot_base[$urandom_range(0, 7)] + $urandom_range(0, 47);
            seq_kind = $urandom_range(0, 99);
            if (seq_kind < 45)
            begin
                send_word(CMD_READ, pick_addr, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
            end
            else if (seq_kind < 65)
            begin
                send_word(CMD_WRITE, pick_addr, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
            end
            else if (seq_kind < 75)
            begin
                send_word(CMD_READ, pick_addr + 32'd8, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
                send_word(CMD_READ, pick_addr + 32'd16, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
                send_word(CMD_WRITE, pick_addr, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
                send_word(CMD_READ, pick_addr + 32'd8, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
            end
            else if (seq_kind < 85)
            begin
                send_word(CMD_READ, pick_addr, $urandom, rand_line());
                send_word(($urandom_range(0, 1) != 0) ? CMD_WRITE : CMD_READ,
                          $urandom, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
                send_word(CMD_FILL, $urandom, $urandom, rand_line());
            end
            else
            begin
                send_word(CMD_W'($urandom_range(0, 3)), $urandom, $urandom, rand_line());
            end
        end
        tx_free = 1'b0;
        rx_free = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("direct_mapped_write_through_cache_unit regression: pass");
        end
        else
        begin
            $display("direct_mapped_write_through_cache_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/dmwtc_pkg.sv
rtl/core/dmwtc_dp.sv
rtl/core/dmwtc_ctrl.sv
rtl/core/direct_mapped_write_through_cache_unit.sv
dv/dmwtc_result_checker.sv
dv/direct_mapped_write_through_cache_unit_tb.sv
